[rtl/core/gdr_pkg.sv]
// Package for the graph downstream reachability unit.
// Holds the request and result payload types, the memory access struct and shared constants.
// Depends on nothing.
package gdr_pkg;

    // Node indices are six bits wide, so at most 64 nodes fit.
    localparam int NODE_W        = 6;
    localparam int SET_W         = 64;
    localparam int NODES_DEFAULT = 64;

    // Operation codes of the request channel.
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [SET_W-1:0] reach_set;
        logic             origin_known;
        logic             edge_added;
    } res_t;

    // One access to the adjacency memory: at most one read and one write per cycle.
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_row;
        logic              wr_en;
        logic [NODE_W-1:0] wr_row;
        logic [SET_W-1:0]  wr_data;
    } adj_req_t;

endpackage

[rtl/core/gdr_adj_mem.sv]
// Adjacency matrix storage for the graph downstream reachability unit.
// One synchronous memory row per node, with a valid bit per row so that reset empties it.
// Depends on gdr_pkg.
module gdr_adj_mem #(
    parameter int NODES = gdr_pkg::NODES_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gdr_pkg::adj_req_t        req,
    output logic [gdr_pkg::SET_W-1:0] rd_data
);

    localparam int IDX_W = $clog2(NODES);

    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] row_valid_reg;
    logic [NODES-1:0] rd_row_reg;
    logic             rd_ok_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_idx = req.rd_row[IDX_W-1:0];
    assign wr_idx = req.wr_row[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_idx] <= req.wr_data[NODES-1:0];
        end
        if (req.rd_en) begin
            rd_row_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_valid_reg[wr_idx] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_ok_reg <= row_valid_reg[rd_idx];
            end
        end
    end

    // A row never written since reset reads as empty.
    assign rd_data = rd_ok_reg ? gdr_pkg::SET_W'(rd_row_reg) : '0;

endmodule

[rtl/core/gdr_pick.sv]
// Lowest pending node selector for the graph downstream reachability unit.
// Isolates the lowest set bit of the pending set and encodes its index.
// Depends on gdr_pkg.
module gdr_pick (
    input  logic [gdr_pkg::SET_W-1:0]  pending,
    output logic                       any,
    output logic [gdr_pkg::SET_W-1:0]  onehot,
    output logic [gdr_pkg::NODE_W-1:0] idx
);

    assign any    = |pending;
    assign onehot = pending & (~pending + gdr_pkg::SET_W'(1));

    always_comb begin
        idx = '0;
        for (int n = 0; n < gdr_pkg::SET_W; n++) begin
            if (onehot[n]) begin
                idx = idx | gdr_pkg::NODE_W'(n);
            end
        end
    end

endmodule

[rtl/core/graph_downstream_reachability_unit.sv]
// Top level of the graph downstream reachability unit.
// Holds the node bitmap, the request sequencer and the lowest-index-first walk over the adjacency memory.
// Depends on gdr_pkg, gdr_adj_mem and gdr_pick.

// The unit keeps a directed graph of up to NODES nodes and serves one request at a time.
// A register request goes from the idle state straight to the done state, which loads the
// result register. A query from an unknown origin and the unused operation code do the same.
// An add-edge request with two distinct known ends passes through the edge-read state, because
// it does one read and one write of the provider's adjacency row. A query from a registered
// origin passes through the walk state, which expands one reached node per cycle through the
// single read port of the adjacency memory. When the pending set runs dry, it waits for the
// row still in flight, and in a long chain each row must come back before the next node can
// be picked. Both the node bitmap and the adjacency matrix are empty right after reset, with
// no clearing pass. A finished result waits in an output register, and a new request is
// taken as soon as the sequencer is idle again. If the previous result has not been taken
// yet, the sequencer holds in its last state until it is.
module graph_downstream_reachability_unit #(
    parameter int NODES = gdr_pkg::NODES_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gdr_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gdr_pkg::res_t m_data
);

    localparam int SET_W  = gdr_pkg::SET_W;
    localparam int NODE_W = gdr_pkg::NODE_W;

    // Bits of the node sets that correspond to real nodes.
    localparam logic [SET_W:0]   NodeMaskW = ({{SET_W{1'b0}}, 1'b1} << NODES) - 1;
    localparam logic [SET_W-1:0] NodeMask  = NodeMaskW[SET_W-1:0];
    localparam logic [NODE_W:0]  NodeLimit = (NODE_W+1)'(NODES);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_EDGE_RD = 4'b0010,
        ST_WALK    = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SET_W-1:0]    nodes_reg, nodes_next;
    logic [SET_W-1:0]    visited_reg, visited_next;
    logic [SET_W-1:0]    pending_reg, pending_next;
    logic                inflight_reg, inflight_next;
    logic [NODE_W-1:0]   node_a_reg, node_a_next;
    logic [NODE_W-1:0]   node_b_reg, node_b_next;
    logic                is_walk_reg, is_walk_next;
    logic                known_reg, known_next;
    logic                added_reg, added_next;
    logic                m_valid_reg, m_valid_next;
    gdr_pkg::res_t       m_data_reg, m_data_next;

    gdr_pkg::adj_req_t   mem_req;
    logic [SET_W-1:0]    mem_rdata;
    logic                pick_any;
    logic [SET_W-1:0]    pick_onehot;
    logic [NODE_W-1:0]   pick_idx;

    logic                accept;
    logic                a_in_range;
    logic                a_known;
    logic                b_known;
    logic [SET_W-1:0]    a_onehot;
    logic [SET_W-1:0]    b_onehot;
    logic [SET_W-1:0]    newly_reached;
    logic                out_free;

    gdr_adj_mem #(
        .NODES(NODES)
    ) u_adj_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mem_req),
        .rd_data(mem_rdata)
    );

    gdr_pick u_pick (
        .pending(pending_reg),
        .any    (pick_any),
        .onehot (pick_onehot),
        .idx    (pick_idx)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Indices at or above NODES are never set in the node bitmap, so a lookup
    // of the bitmap alone tells whether a node is known.
    assign a_in_range = {1'b0, s_data.node_a} < NodeLimit;
    assign a_known    = nodes_reg[s_data.node_a];
    assign b_known    = nodes_reg[s_data.node_b];
    assign a_onehot   = SET_W'(1) << s_data.node_a;
    assign b_onehot   = SET_W'(1) << node_b_reg;

    // Row data of the node expanded in the previous walk cycle, less what is already reached.
    assign newly_reached = inflight_reg ? (mem_rdata & NodeMask & ~visited_reg) : '0;

    always_comb begin
        state_next    = state_reg;
        nodes_next    = nodes_reg;
        visited_next  = visited_reg;
        pending_next  = pending_reg;
        inflight_next = 1'b0;
        node_a_next   = node_a_reg;
        node_b_next   = node_b_reg;
        is_walk_next  = is_walk_reg;
        known_next    = known_reg;
        added_next    = added_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        mem_req         = '0;
        mem_req.rd_row  = node_a_reg;
        mem_req.wr_row  = node_a_reg;
        mem_req.wr_data = mem_rdata | b_onehot;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    node_a_next  = s_data.node_a;
                    node_b_next  = s_data.node_b;
                    is_walk_next = 1'b0;
                    added_next   = 1'b0;
                    known_next   = a_known;
                    state_next   = ST_DONE;
                    unique case (s_data.operation)
                        gdr_pkg::OP_REGISTER: begin
                            if (a_in_range) begin
                                nodes_next = nodes_reg | a_onehot;
                                known_next = 1'b1;
                            end
                        end
                        gdr_pkg::OP_ADD_EDGE: begin
                            // Self edges and edges with an unknown end are dropped.
                            if (s_data.node_a != s_data.node_b && a_known && b_known) begin
                                mem_req.rd_en  = 1'b1;
                                mem_req.rd_row = s_data.node_a;
                                state_next     = ST_EDGE_RD;
                            end
                        end
                        gdr_pkg::OP_QUERY: begin
                            if (a_known) begin
                                visited_next = a_onehot;
                                pending_next = a_onehot;
                                is_walk_next = 1'b1;
                                state_next   = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_EDGE_RD: begin
                // The provider's row is back: set the consumer's bit and write it back.
                mem_req.wr_en = 1'b1;
                added_next    = 1'b1;
                state_next    = ST_DONE;
            end

            ST_WALK: begin
                // Expand the lowest pending node each cycle while the row of the node
                // picked in the previous cycle is merged into the reached set.
                mem_req.rd_en  = pick_any;
                mem_req.rd_row = pick_idx;
                inflight_next  = pick_any;
                visited_next   = visited_reg | newly_reached;
                pending_next   = (pending_reg & ~pick_onehot) | newly_reached;
                if (!pick_any && !inflight_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_data_next.reach_set    = is_walk_reg ? visited_reg : '0;
                    m_data_next.origin_known = known_reg;
                    m_data_next.edge_added   = added_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nodes_reg    <= '0;
            visited_reg  <= '0;
            pending_reg  <= '0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nodes_reg    <= nodes_next;
            visited_reg  <= visited_next;
            pending_reg  <= pending_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_a_reg  <= node_a_next;
        node_b_reg  <= node_b_next;
        is_walk_reg <= is_walk_next;
        known_reg   <= known_next;
        added_reg   <= added_next;
        m_data_reg  <= m_data_next;
    end

endmodule

[bench/tb_graph_downstream_reachability_unit.sv]
// Self-checking testbench for graph_downstream_reachability_unit.
// It predicts results from its model of the node bitmap and adjacency matrix, bar typed rows.
// It depends on gdr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_graph_downstream_reachability_unit;

    localparam int NODES = gdr_pkg::NODES_DEFAULT;
    // No name exists in the package for the fourth operation code, which the unit must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Together with the directed rows this makes about 1950 requests.
    localparam int RANDOM_REQUESTS = 1926;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    gdr_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    gdr_pkg::res_t m_data;

    graph_downstream_reachability_unit #(
        .NODES(NODES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The testbench's own copy of the graph. It is updated in request order, at the
    // moment each request is accepted, so the queue of results always matches the
    // order in which the unit must answer.
    logic [NODES-1:0] known_nodes = '0;
    logic [NODES-1:0] edge_rows [NODES];
    gdr_pkg::res_t    pending_results [$];

    int mismatches = 0;
    int requests_sent = 0;
    int queries_seen = 0;
    int nonempty_sets = 0;
    int edges_accepted = 0;
    int widest_set = 0;

    initial begin
        for (int n = 0; n < NODES; n++) begin
            edge_rows[n] = '0;
        end
    end

    function automatic bit is_known(input logic [gdr_pkg::NODE_W-1:0] n);
        return (n < NODES) && known_nodes[n];
    endfunction

    // Level-by-level walk: each pass ORs together the rows of the current wavefront
    // and keeps only nodes that were not reached before. The origin is always included.
    function automatic logic [gdr_pkg::SET_W-1:0] downstream_of(
        input logic [gdr_pkg::NODE_W-1:0] origin);
        logic [NODES-1:0] seen;
        logic [NODES-1:0] wave;
        logic [NODES-1:0] grow;
        seen = '0;
        seen[origin] = 1'b1;
        wave = seen;
        while (wave != '0) begin
            grow = '0;
            for (int n = 0; n < NODES; n++) begin
                if (wave[n]) begin
                    grow |= edge_rows[n];
                end
            end
            grow &= ~seen;
            seen |= grow;
            wave = grow;
        end
        return gdr_pkg::SET_W'(seen);
    endfunction

    // Applies one request to the model graph and returns the result the unit owes for it.
    function automatic gdr_pkg::res_t graph_outcome(input gdr_pkg::req_t req);
        gdr_pkg::res_t r;
        r = '0;
        case (req.operation)
            gdr_pkg::OP_REGISTER: begin
                if (req.node_a < NODES) begin
                    known_nodes[req.node_a] = 1'b1;
                end
            end
            gdr_pkg::OP_ADD_EDGE: begin
                if (req.node_a != req.node_b && is_known(req.node_a) && is_known(req.node_b)) begin
                    edge_rows[req.node_a][req.node_b] = 1'b1;
                    r.edge_added = 1'b1;
                    edges_accepted++;
                end
            end
            gdr_pkg::OP_QUERY: begin
                queries_seen++;
                if (is_known(req.node_a)) begin
                    r.reach_set = downstream_of(req.node_a);
                    nonempty_sets++;
                    if ($countones(r.reach_set) > widest_set) begin
                        widest_set = $countones(r.reach_set);
                    end
                end
            end
            default: begin
            end
        endcase
        r.origin_known = is_known(req.node_a);
        return r;
    endfunction

    // The receiver stalls on a 32-bit pattern that is redrawn at every wrap of its phase: sometimes
    // always ready, sometimes mostly ready, sometimes mostly stalled.
    logic [31:0] stall_pattern = '1;
    logic [4:0]  stall_phase = '0;

    always @(posedge aclk) begin
        if (stall_phase == 5'd31) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= '1;
                1: stall_pattern <= $urandom | $urandom;
                2: stall_pattern <= $urandom & $urandom;
                default: stall_pattern <= $urandom;
            endcase
        end
        stall_phase <= stall_phase + 5'd1;
        m_ready <= stall_pattern[stall_phase];
    end

    // Every accepted result is compared with the oldest expectation. Outputs are read in
    // the active region at the edge, so they hold the values from before the edge.
    always @(posedge aclk) begin : check_results
        gdr_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got reach_set=%h known=%b added=%b",
                         $time, m_data.reach_set, m_data.origin_known, m_data.edge_added);
            end else begin
                want = pending_results.pop_front();
                if (m_data.reach_set !== want.reach_set) begin
                    mismatches++;
                    $display("%0t: reach_set expected %h, actual %h",
                             $time, want.reach_set, m_data.reach_set);
                end
                if (m_data.origin_known !== want.origin_known) begin
                    mismatches++;
                    $display("%0t: origin_known expected %b, actual %b",
                             $time, want.origin_known, m_data.origin_known);
                end
                if (m_data.edge_added !== want.edge_added) begin
                    mismatches++;
                    $display("%0t: edge_added expected %b, actual %b",
                             $time, want.edge_added, m_data.edge_added);
                end
            end
        end
    end

    // The sender works in bursts of random length. Between bursts valid drops for a random
    // gap; a gap of zero joins two bursts into one unbroken stretch.
    int burst_left = 0;

    task automatic send_request(input gdr_pkg::req_t req, input bit use_typed,
                                input gdr_pkg::res_t typed_want);
        int gap;
        gdr_pkg::res_t predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // The request was taken at this edge: update the model graph now, in order.
        predicted = graph_outcome(req);
        pending_results.insert(pending_results.size(), use_typed ? typed_want : predicted);
        requests_sent++;
    endtask

    // Picks a registered node most of the time, so that edges and queries land on live
    // parts of the graph; otherwise any index, which exercises the rejection paths.
    function automatic logic [gdr_pkg::NODE_W-1:0] pick_node();
        logic [gdr_pkg::NODE_W-1:0] n;
        n = gdr_pkg::NODE_W'($urandom_range(0, NODES - 1));
        if (known_nodes != '0 && $urandom_range(0, 4) != 0) begin
            for (int tries = 0; tries < 4 * NODES && !known_nodes[n]; tries++) begin
                n = gdr_pkg::NODE_W'($urandom_range(0, NODES - 1));
            end
        end
        return n;
    endfunction

    // Random requests: a few registrations, many edges (three in eight of them short forward
    // hops, which build long chains), many queries, and a little noise of the unused code.
    function automatic gdr_pkg::req_t random_request();
        gdr_pkg::req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        r.node_b = gdr_pkg::NODE_W'($urandom_range(0, NODES - 1));
        if (roll < 4) begin
            r.operation = OP_UNUSED;
            r.node_a = gdr_pkg::NODE_W'($urandom_range(0, NODES - 1));
        end else if (roll < 16) begin
            r.operation = gdr_pkg::OP_REGISTER;
            r.node_a = gdr_pkg::NODE_W'($urandom_range(0, NODES - 1));
        end else if (roll < 60) begin
            r.operation = gdr_pkg::OP_ADD_EDGE;
            r.node_a = pick_node();
            case ($urandom_range(0, 7)) inside
                0: r.node_b = r.node_a;
                [1:3]: r.node_b = r.node_a + gdr_pkg::NODE_W'($urandom_range(1, 3));
                default: r.node_b = pick_node();
            endcase
        end else begin
            r.operation = gdr_pkg::OP_QUERY;
            r.node_a = pick_node();
        end
        return r;
    endfunction

    typedef struct {
        gdr_pkg::req_t req;
        bit            typed;
        gdr_pkg::res_t want;
    } stim_row_t;

    // Directed opening. Rows marked typed carry the result written out by hand; the rest
    // are checked against the model graph. The run starts from an empty graph.
    stim_row_t directed_rows [24] = '{
        '{'{gdr_pkg::OP_QUERY,    6'd0,  6'd0},  1'b1, '{64'h0, 1'b0, 1'b0}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd0,  6'd1},  1'b1, '{64'h0, 1'b0, 1'b0}},
        '{'{OP_UNUSED,            6'd63, 6'd63}, 1'b1, '{64'h0, 1'b0, 1'b0}},
        '{'{gdr_pkg::OP_REGISTER, 6'd63, 6'd0},  1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_REGISTER, 6'd0,  6'd0},  1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_REGISTER, 6'd0,  6'd0},  1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_QUERY,    6'd63, 6'd0},  1'b1, '{64'h8000_0000_0000_0000, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd63, 6'd63}, 1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd0,  6'd63}, 1'b1, '{64'h0, 1'b1, 1'b1}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd0,  6'd63}, 1'b1, '{64'h0, 1'b1, 1'b1}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd0,  6'd5},  1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd5,  6'd0},  1'b1, '{64'h0, 1'b0, 1'b0}},
        '{'{gdr_pkg::OP_QUERY,    6'd0,  6'd0},  1'b1, '{64'h8000_0000_0000_0001, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_REGISTER, 6'd42, 6'd0},  1'b0, '0},
        '{'{gdr_pkg::OP_REGISTER, 6'd21, 6'd0},  1'b0, '0},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd63, 6'd42}, 1'b0, '0},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd42, 6'd21}, 1'b0, '0},
        '{'{gdr_pkg::OP_ADD_EDGE, 6'd21, 6'd0},  1'b0, '0},
        '{'{gdr_pkg::OP_QUERY,    6'd63, 6'd0},  1'b0, '0},
        '{'{gdr_pkg::OP_QUERY,    6'd21, 6'd0},  1'b0, '0},
        '{'{OP_UNUSED,            6'd42, 6'd21}, 1'b1, '{64'h0, 1'b1, 1'b0}},
        '{'{gdr_pkg::OP_QUERY,    6'd5,  6'd0},  1'b1, '{64'h0, 1'b0, 1'b0}},
        '{'{gdr_pkg::OP_QUERY,    6'd42, 6'd63}, 1'b0, '0},
        '{'{gdr_pkg::OP_REGISTER, 6'd5,  6'd63}, 1'b1, '{64'h0, 1'b1, 1'b0}}
    };

    initial begin : stimulus
        gdr_pkg::req_t req;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        repeat (RANDOM_REQUESTS) begin
            req = random_request();
            send_request(req, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Drain, then allow one worst-case walk more so that a stray result would show up.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2 * NODES + 8) @(posedge aclk);

        $display("Sent %0d requests: %0d queries (%0d from registered origins, widest set %0d),",
                 requests_sent, queries_seen, nonempty_sets, widest_set);
        $display("%0d edges accepted, %0d of %0d nodes registered at the end.",
                 edges_accepted, $countones(known_nodes), NODES);
        if (mismatches == 0) begin
            $display("graph_downstream_reachability_unit: match");
        end else begin
            $display("graph_downstream_reachability_unit: mismatch");
        end
        $finish;
    end

    // Safety net: even with every query walking the longest chain under heavy stalls, a
    // correct run stays well under a tenth of this.
    initial begin : watchdog
        #50_000_000;
        $display("Timed out with %0d results still expected.", pending_results.size());
        $display("graph_downstream_reachability_unit: mismatch");
        $finish;
    end

endmodule
